// ----- hdl/vtpd_pkg.sv -----
// Package for the vertex transform with perspective divide.
// Fixed-point widths, pipeline sideband type and the saturation helper.
// No dependencies.
package vtpd_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned NumW     = SumW + FracBits;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 128;

  localparam logic OpWrite     = 1'b0;
  localparam logic OpTransform = 1'b1;

  typedef struct packed {
    logic [DataW-1:0] pass_x;
    logic [DataW-1:0] pass_y;
    logic [DataW-1:0] pass_z;
    logic             w_zero;
    logic [2:0]       neg;
    logic [2:0]       ovf;
  } side_t;

  function automatic logic [DataW-1:0] sat32(input logic [SumW-1:0] mag, input logic neg);
    logic [SumW-1:0] lim;
    logic [DataW-1:0] res;
    if (neg) begin
      lim = SumW'({1'b1, {(DataW-1){1'b0}}});
      res = (mag > lim) ? {1'b1, {(DataW-1){1'b0}}} : (DataW'(0) - mag[DataW-1:0]);
    end else begin
      lim = SumW'({1'b0, {(DataW-1){1'b1}}});
      res = (mag > lim) ? {1'b0, {(DataW-1){1'b1}}} : mag[DataW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/vertex_transform_perspective_divide.sv -----
// Top level: 4x4 Q16.16 vertex transform with perspective divide.
// Depends on vtpd_pkg and vtpd_div_lane.
//
// Usage:
//  Slave stream carries load and transform words; tuser = op (0 load entry,
//  1 transform vertex). A load word writes one matrix entry and gives no
//  output. A transform word gives one output word: x, y, z divided by the
//  transformed w (truncated, saturated) and w = 1.0, or, when w is zero,
//  the products scaled back and saturated, w = 0 and tuser (w_was_zero) set.
//  Path: a transform word is loaded into the input register at the edge
//  that accepts it, then passes multiply, sum, prepare, 32 divide stages
//  and the output register before it shows on the master side.
//  Throughput: one word per cycle while the receiver does not stall; the
//  divider is a 32 stage pipeline, one quotient bit per stage, three lanes for x, y and z.
//  A load takes effect for every transform accepted after it.
//  Reset clears the matrix to zero and empties the pipeline.
//  When the receiver stalls with an output waiting, the whole pipeline
//  holds and s_axis_tready drops; nothing is lost or repeated.
module vertex_transform_perspective_divide (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_row[1:0], entry_col[3:2], entry_value[35:4], in_x, in_y, in_z, in_w, zero pad
  input  logic [vtpd_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_x[31:0], out_y, out_z, out_w
  output logic [vtpd_pkg::OutDataW-1:0]  m_axis_tdata,
  // w_was_zero
  output logic                           m_axis_tuser
);

  localparam int unsigned W  = vtpd_pkg::DataW;
  localparam int unsigned SW = vtpd_pkg::SumW;
  localparam int unsigned Steps = vtpd_pkg::QuoW;

  logic en;
  logic out_valid_q;

  assign en = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // matrix, index row*4+col
  logic [W-1:0] matrix_q [16];
  logic [3:0]   wr_idx;
  logic         wr_en;
  assign wr_idx = {s_axis_tdata[1:0], s_axis_tdata[3:2]};
  assign wr_en  = s_axis_tvalid && en && (s_axis_tuser == vtpd_pkg::OpWrite);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
    end else if (wr_en) begin
      matrix_q[wr_idx] <= s_axis_tdata[35:4];
    end
  end

  // stage 1: vertex register
  logic         v1_q, v2_q, v3_q, v4_q;
  logic [W-1:0] vec_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid && (s_axis_tuser == vtpd_pkg::OpTransform);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) vec_q[i] <= s_axis_tdata[36 + 32*i +: 32];
    end
  end

  // stage 2: products
  logic signed [vtpd_pkg::ProdW-1:0] prod_q [16];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[i*4+c] <= $signed(vec_q[i]) * $signed(matrix_q[i*4+c]);
        end
      end
    end
  end

  // stage 3: column sums
  logic signed [SW-1:0] sum_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SW'(prod_q[c]) + SW'(prod_q[4+c]) + SW'(prod_q[8+c]) + SW'(prod_q[12+c]);
      end
    end
  end

  // stage 4: magnitudes, overflow test, divider seed
  logic [SW-1:0]              mag [4];
  logic [vtpd_pkg::NumW-1:0]  num [3];
  logic [SW-1:0]              num_hi [3];
  vtpd_pkg::side_t            side_d, side_q;
  logic [SW-1:0]              rem_d [3];
  logic [SW-1:0]              rem_q [3];
  logic [Steps-1:0]           lo_q  [3];
  logic [SW-1:0]              den_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = sum_q[c][SW-1] ? SW'(-sum_q[c]) : SW'(sum_q[c]);
    end
    side_d.w_zero = (sum_q[3] == '0);
    side_d.pass_x = vtpd_pkg::sat32(mag[0] >> vtpd_pkg::FracBits, sum_q[0][SW-1]);
    side_d.pass_y = vtpd_pkg::sat32(mag[1] >> vtpd_pkg::FracBits, sum_q[1][SW-1]);
    side_d.pass_z = vtpd_pkg::sat32(mag[2] >> vtpd_pkg::FracBits, sum_q[2][SW-1]);
    for (int c = 0; c < 3; c++) begin
      num[c]         = {mag[c], {vtpd_pkg::FracBits{1'b0}}};
      num_hi[c]      = SW'(num[c][vtpd_pkg::NumW-1:Steps]);
      side_d.ovf[c]  = (num_hi[c] >= mag[3]);
      side_d.neg[c]  = sum_q[c][SW-1] ^ sum_q[3][SW-1];
      rem_d[c]       = num_hi[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
      den_q  <= mag[3];
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= rem_d[c];
        lo_q[c]  <= num[c][Steps-1:0];
      end
    end
  end

  // divider lanes and matching sideband
  logic [Steps-1:0] quo [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    vtpd_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem_q[c]),
      .den_i (den_q),
      .lo_i  (lo_q[c]),
      .quo_o (quo[c])
    );
  end

  logic             vd_q   [Steps];
  vtpd_pkg::side_t  sided_q [Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Steps; k++) vd_q[k] <= 1'b0;
    end else if (en) begin
      vd_q[0] <= v4_q;
      for (int k = 1; k < Steps; k++) vd_q[k] <= vd_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sided_q[0] <= side_q;
      for (int k = 1; k < Steps; k++) sided_q[k] <= sided_q[k-1];
    end
  end

  // output register
  vtpd_pkg::side_t   sf;
  logic [W-1:0]      res [3];
  logic [SW-1:0]     qmag [3];
  logic [vtpd_pkg::OutDataW-1:0] data_d, data_q;
  logic              zero_q;

  always_comb begin
    sf = sided_q[Steps-1];
    for (int c = 0; c < 3; c++) begin
      qmag[c] = sf.ovf[c] ? {SW{1'b1}} : SW'(quo[c]);
      res[c]  = vtpd_pkg::sat32(qmag[c], sf.neg[c]);
    end
    if (sf.w_zero) begin
      data_d = {W'(0), sf.pass_z, sf.pass_y, sf.pass_x};
    end else begin
      data_d = {W'(1) << vtpd_pkg::FracBits, res[2], res[1], res[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      zero_q <= sf.w_zero;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = zero_q;

`ifndef SYNTHESIS
  a_zero_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[127:96] == '0))
    else $error("w output not zero on skipped divide");

  a_one_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[127:96] == (W'(1) << vtpd_pkg::FracBits)))
    else $error("w output not 1.0 after divide");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !en) |=> v4_q)
    else $error("pipeline item lost during stall");
`endif

endmodule

// ----- hdl/vtpd_div_lane.sv -----
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on vtpd_pkg.
module vtpd_div_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [vtpd_pkg::SumW-1:0]     rem_i,
  input  logic [vtpd_pkg::SumW-1:0]     den_i,
  input  logic [vtpd_pkg::QuoW-1:0]     lo_i,
  output logic [vtpd_pkg::QuoW-1:0]     quo_o
);

  localparam int unsigned Steps = vtpd_pkg::QuoW;

  logic [vtpd_pkg::SumW-1:0] rem_q [Steps];
  logic [vtpd_pkg::SumW-1:0] den_q [Steps];
  logic [vtpd_pkg::QuoW-1:0] lo_q  [Steps];
  logic [vtpd_pkg::QuoW-1:0] quo_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [vtpd_pkg::SumW-1:0] rem_in, den_in;
    logic [vtpd_pkg::QuoW-1:0] lo_in, quo_in;
    logic [vtpd_pkg::SumW:0]   trial;
    logic [vtpd_pkg::SumW:0]   den_ext;
    logic                      fit;
    logic [vtpd_pkg::SumW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign lo_in  = lo_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial   = {rem_in, lo_in[vtpd_pkg::QuoW-1]};
      den_ext = {1'b0, den_in};
      fit     = (trial >= den_ext);
      rem_d   = fit ? vtpd_pkg::SumW'(trial - den_ext) : trial[vtpd_pkg::SumW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        lo_q[k]  <= {lo_in[vtpd_pkg::QuoW-2:0], 1'b0};
        quo_q[k] <= {quo_in[vtpd_pkg::QuoW-2:0], fit};
      end
    end
  end

  assign quo_o = quo_q[Steps-1];

endmodule
